### rtl/wlm_pkg.sv
// Wildcard line matcher package: shared constants, register indexes and types.
// Used by the segment finder and the top level. No dependencies.
`default_nettype none

package wlm_pkg;

  // Pattern byte that matches any run of line bytes
  localparam logic [7:0] STAR_CHAR = 8'h2A;

  // Pattern positions: the length register is 5 bits, so positions fit in 5 bits
  localparam int unsigned POS_W   = 5;
  localparam int unsigned NUM_POS = 32;

  // Byte count since the current segment search began saturates here
  localparam logic [POS_W-1:0] COUNT_MAX = 5'd31;

  // Width of the configuration write data and register index
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LOW  = 2'd0,
    REG_PAT_HIGH = 2'd1,
    REG_PAT_LEN  = 2'd2
  } cfg_reg_e;

  typedef logic [POS_W-1:0] pos_t;

  // All pattern positions; positions 16 and above always read as zero
  typedef logic [NUM_POS-1:0][7:0] pat_bytes_t;

  // Result of the search for the next literal segment of the pattern
  typedef struct packed {
    logic found;           // a literal segment remains at or after the start
    pos_t start_c;         // search start clamped to the pattern length
    pos_t seg_end;         // first position after that segment
    pos_t seg_len;         // number of bytes in that segment
    logic more_after_end;  // another literal byte follows the segment
  } seg_info_t;

endpackage

`default_nettype wire

### rtl/wlm_if.sv
// Handshake channels of the wildcard line matcher: line items in, match results out.
// Depends on nothing; valid and ready are both high at a transfer.
`default_nettype none

interface wlm_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       byte_present;
  logic       end_of_line;

  modport source (output valid, line_byte, byte_present, end_of_line, input ready);
  modport sink   (input valid, line_byte, byte_present, end_of_line, output ready);
endinterface

interface wlm_result_if;
  logic valid;
  logic ready;
  logic line_matches;

  modport source (output valid, line_matches, input ready);
  modport sink   (input valid, line_matches, output ready);
endinterface

`default_nettype wire

### rtl/wildcard_line_matcher.sv
// Wildcard line matcher top level: window cell chain, segment tracking and
// a two-entry result buffer. Uses wlm_pkg, wlm_if, wlm_cell and wlm_seg_find.
//
// Usage:
//   item_i carries one line byte per transfer, with byte_present (0 on an
//   item that holds no byte, e.g. an empty line) and end_of_line on the last
//   item of each line. result_o carries one line_matches bit per line.
//   The pattern (up to 16 bytes, '*' matches any run, implicit stars at both
//   ends) is written through cfg_we_i / cfg_idx_i / cfg_wdata_i: index 0 holds
//   bytes 0..7, index 1 bytes 8..15, index 2 the length; other indexes drop.
//   Throughput: one item per cycle while item_i.ready is high. The window compare
//   and segment search finish in the cycle of the transfer, so the next item may follow at once.
//   Result: a line's result enters the result buffer with the transfer of its
//   end_of_line item, and result_o.valid is high in the cycle after.
//   Stall: results queue in a two-entry buffer; item_i.ready drops only while
//   two results wait, and items without end_of_line still flow while one waits.
//   Reset: clears the pattern (empty, so every line matches), the window, the
//   segment state and the result buffer. No clearing pass is needed.
`default_nettype none

module wildcard_line_matcher #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  wlm_item_if.sink                            item_i,
  wlm_result_if.source                        result_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [wlm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [wlm_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  // Configuration registers
  logic [63:0]   pat_low_q;
  logic [63:0]   pat_high_q;
  wlm_pkg::pos_t pat_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wlm_pkg::REG_PAT_LOW:  pat_low_q  <= cfg_wdata_i;
        wlm_pkg::REG_PAT_HIGH: pat_high_q <= cfg_wdata_i;
        wlm_pkg::REG_PAT_LEN:  pat_len_q  <= cfg_wdata_i[wlm_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  wlm_pkg::pat_bytes_t pat;
  wlm_pkg::pos_t       eff_len;

  always_comb begin
    for (int i = 0; i < wlm_pkg::NUM_POS; i++) begin
      if (i < 8) begin
        pat[i] = pat_low_q[8*i +: 8];
      end else if (i < 16) begin
        pat[i] = pat_high_q[8*(i-8) +: 8];
      end else begin
        pat[i] = 8'h00;
      end
    end
  end

  assign eff_len = (32'(pat_len_q) > PATTERN_MAX) ? wlm_pkg::pos_t'(PATTERN_MAX) : pat_len_q;

  // Line state
  wlm_pkg::pos_t seg_start_q, seg_start_d;
  wlm_pkg::pos_t count_q, count_d;
  logic          seen_q, seen_d;

  logic          accept;
  logic          present;
  logic          eol;
  wlm_pkg::pos_t count_inc;
  logic          hit;
  logic          line_match;

  assign accept  = item_i.valid && item_i.ready;
  assign present = item_i.byte_present;
  assign eol     = item_i.end_of_line;

  wlm_pkg::seg_info_t seg;

  wlm_seg_find u_seg_find (
    .pat_i   (pat),
    .len_i   (eff_len),
    .start_i (seg_start_q),
    .seg_o   (seg)
  );

  // Window chain: cell 0 takes the new byte, each cell feeds the next
  logic [7:0]             win_byte [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] cell_hit;

  for (genvar w = 0; w < PATTERN_MAX; w++) begin : g_cell
    logic [7:0]    byte_in;
    wlm_pkg::pos_t ref_idx;
    logic          care;

    if (w == 0) begin : g_head
      assign byte_in = item_i.line_byte;
    end else begin : g_link
      assign byte_in = win_byte[w-1];
    end

    // Window slot w lines up with pattern position seg_end - 1 - w
    assign ref_idx = seg.seg_end - wlm_pkg::pos_t'(1) - wlm_pkg::pos_t'(w);
    assign care    = w < int'(seg.seg_len);

    wlm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (accept && present),
      .byte_i  (byte_in),
      .ref_i   (pat[ref_idx]),
      .care_i  (care),
      .byte_o  (win_byte[w]),
      .hit_o   (cell_hit[w])
    );
  end

  always_comb begin
    count_inc = count_q;
    if (present && (count_q != wlm_pkg::COUNT_MAX)) begin
      count_inc = count_q + wlm_pkg::pos_t'(1);
    end
  end

  assign hit = present && seg.found && (32'(seg.seg_len) <= PATTERN_MAX)
            && (count_inc >= seg.seg_len) && (&cell_hit);

  assign line_match = (eff_len == '0)
                   || ((seen_q || present) && !(hit ? seg.more_after_end : seg.found));

  always_comb begin
    seg_start_d = seg_start_q;
    count_d     = count_q;
    seen_d      = seen_q;
    if (accept) begin
      if (eol) begin
        seg_start_d = '0;
        count_d     = '0;
        seen_d      = 1'b0;
      end else begin
        seg_start_d = hit ? seg.seg_end : seg.start_c;
        count_d     = hit ? '0 : count_inc;
        seen_d      = seen_q || present;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_start_q <= '0;
      count_q     <= '0;
      seen_q      <= 1'b0;
    end else begin
      seg_start_q <= seg_start_d;
      count_q     <= count_d;
      seen_q      <= seen_d;
    end
  end

  // Two-entry result buffer
  logic       res_mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] res_cnt_q, res_cnt_d;
  logic       push;
  logic       pop;

  assign push = accept && eol;
  assign pop  = result_o.valid && result_o.ready;

  always_comb begin
    wr_ptr_d  = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d  = pop ? !rd_ptr_q : rd_ptr_q;
    res_cnt_d = res_cnt_q;
    if (push && !pop) begin
      res_cnt_d = res_cnt_q + 2'd1;
    end else if (pop && !push) begin
      res_cnt_d = res_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= 1'b0;
      rd_ptr_q  <= 1'b0;
      res_cnt_q <= 2'd0;
    end else begin
      wr_ptr_q  <= wr_ptr_d;
      rd_ptr_q  <= rd_ptr_d;
      res_cnt_q <= res_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      res_mem_q[wr_ptr_q] <= line_match;
    end
  end

  assign item_i.ready          = (res_cnt_q != 2'd2);
  assign result_o.valid        = (res_cnt_q != 2'd0);
  assign result_o.line_matches = res_mem_q[rd_ptr_q];

endmodule

`default_nettype wire

### rtl/wlm_cell.sv
// One window cell: holds a recent line byte, passes it on to the next cell,
// and compares the byte it is about to take against its aligned pattern byte.
`default_nettype none

module wlm_cell (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       shift_i,
  input  wire logic [7:0] byte_i,
  input  wire logic [7:0] ref_i,
  input  wire logic       care_i,
  output logic      [7:0] byte_o,
  output logic            hit_o
);

  logic [7:0] byte_q;
  logic [7:0] byte_d;

  assign byte_d = shift_i ? byte_i : byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else begin
      byte_q <= byte_d;
    end
  end

  // Compare the incoming byte: the window as it stands after this shift
  assign hit_o  = !care_i || (byte_i == ref_i);
  assign byte_o = byte_q;

endmodule

`default_nettype wire

### rtl/wlm_seg_find.sv
// Segment finder: locates the next literal segment of the pattern at or after
// the search start, and whether literal bytes remain after it. Uses wlm_pkg.
`default_nettype none

module wlm_seg_find (
  input  wire wlm_pkg::pat_bytes_t pat_i,
  input  wire wlm_pkg::pos_t       len_i,
  input  wire wlm_pkg::pos_t       start_i,
  output wlm_pkg::seg_info_t       seg_o
);

  logic [wlm_pkg::NUM_POS-1:0] lit_vec;
  logic [wlm_pkg::NUM_POS-1:0] cand_vec;
  logic [wlm_pkg::NUM_POS-1:0] end_vec;
  wlm_pkg::pos_t               start_c;
  wlm_pkg::pos_t               seg_s;
  wlm_pkg::pos_t               seg_e;

  assign start_c = (start_i > len_i) ? len_i : start_i;

  always_comb begin
    for (int i = 0; i < wlm_pkg::NUM_POS; i++) begin
      lit_vec[i] = (wlm_pkg::pos_t'(i) < len_i) && (pat_i[i] != wlm_pkg::STAR_CHAR);
    end
  end

  assign cand_vec = lit_vec & ({wlm_pkg::NUM_POS{1'b1}} << start_c);

  // A segment ends where a star or the pattern end follows a literal byte
  always_comb begin
    end_vec[0] = 1'b0;
    for (int i = 1; i < wlm_pkg::NUM_POS; i++) begin
      end_vec[i] = !lit_vec[i] && cand_vec[i-1];
    end
  end

  // Lowest set position of each vector
  always_comb begin
    seg_s = '0;
    seg_e = '0;
    for (int i = wlm_pkg::NUM_POS - 1; i >= 0; i--) begin
      if (cand_vec[i]) begin
        seg_s = wlm_pkg::pos_t'(i);
      end
      if (end_vec[i]) begin
        seg_e = wlm_pkg::pos_t'(i);
      end
    end
  end

  assign seg_o.found          = |cand_vec;
  assign seg_o.start_c        = start_c;
  assign seg_o.seg_end        = seg_e;
  assign seg_o.seg_len        = seg_e - seg_s;
  assign seg_o.more_after_end = |(lit_vec >> seg_e);

endmodule

`default_nettype wire

### rtl/wlm_checker.sv
// Port-level checker for the wildcard line matcher, bound to the top level.
// Sees only the top level's ports; depends on nothing else.
`default_nettype none

module wlm_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic in_eol_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic out_match_i
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_match_i))
    else $error("result changed while stalled");

  // The transfer of a line's last item leaves a result on offer next cycle
  a_eol_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_eol_i |=> out_valid_i)
    else $error("no result after end of line");

  // Input backpressure only comes from waiting results
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no result waiting");

  // Backpressure needs an earlier end of line
  a_stall_after_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(in_valid_i && in_eol_i))
    else $error("input stalled without a preceding end of line");

endmodule

bind wildcard_line_matcher wlm_checker u_wlm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .in_eol_i    (item_i.end_of_line),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_match_i (result_o.line_matches)
);

`default_nettype wire
